[design/rans_static_encoder_assert.svh]
// ---------------------------------------------------------------------------
// rANS encoder assertion macros
// Concurrent property wrappers clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef RANS_STATIC_ENCODER_ASSERT_SVH
`define RANS_STATIC_ENCODER_ASSERT_SVH

// same-cycle implication
`define RSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rse assertion failed");

// next-cycle implication
`define RSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rse assertion failed");

`endif

[design/rse_pkg.sv]
// ---------------------------------------------------------------------------
// rse_pkg
// Constants, state encoding and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package rse_pkg;

	localparam int PROB_BITS      = 16;
	localparam int LOW_BOUND_BITS = 23;
	localparam int TABLE_DEPTH    = 256;

	localparam int VALUE_BITS = LOW_BOUND_BITS + 8;
	// quotient width after renormalization: x < f << QUOT_BITS
	localparam int QUOT_BITS  = LOW_BOUND_BITS - PROB_BITS + 8;
	localparam int TBL_AW     = $clog2(TABLE_DEPTH);
	localparam int SYMCNT_W   = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int DIV_CW     = $clog2(QUOT_BITS + 1);
	localparam int RENORM_MAX = 2;
	localparam int FLUSH_BYTES = 4;

	localparam logic [VALUE_BITS-1:0] VALUE_RESET = VALUE_BITS'(1) << LOW_BOUND_BITS;
	localparam logic [SYMCNT_W-1:0]   SYMCNT_RESET = SYMCNT_W'(256);
	localparam logic [BYTE_W-1:0]     BYTE_MASK = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_ERR,
		ST_RENORM,
		ST_DIV,
		ST_UPDATE,
		ST_FLUSH
	} rse_state_t;

	typedef struct packed {
		logic tbl_write;
		logic load_item;
		logic value_reset;
		logic failed_set;
		logic failed_clr;
		logic emit_err;
		logic emit_renorm;
		logic div_init;
		logic div_step;
		logic update;
		logic emit_flush;
	} rse_cmd_t;

	typedef struct packed {
		logic failed;
		logic bad;
		logic renorm_need;
		logic slot_free;
		logic div_last;
		logic flush_last;
		logic item_final;
	} rse_status_t;

endpackage

[design/rse_sym_if.sv]
// ---------------------------------------------------------------------------
// rse_sym_if
// Input channel: table-load and encode beats.
// ---------------------------------------------------------------------------
interface rse_sym_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [rse_pkg::SYM_W-1:0]   symbol;
	logic [rse_pkg::PROB_BITS-1:0] frequency;
	logic [rse_pkg::PROB_BITS-1:0] cum_start;
	logic                        is_final;

	modport source (output valid, action, symbol, frequency, cum_start, is_final,
		input ready);
	modport sink (input valid, action, symbol, frequency, cum_start, is_final,
		output ready);
endinterface

[design/rse_code_if.sv]
// ---------------------------------------------------------------------------
// rse_code_if
// Output channel: coded byte beats and error beats.
// ---------------------------------------------------------------------------
interface rse_code_if;
	logic                       valid;
	logic                       ready;
	logic [rse_pkg::BYTE_W-1:0] out_byte;
	logic                       out_last;
	logic                       error;

	modport source (output valid, out_byte, out_last, error, input ready);
	modport sink (input valid, out_byte, out_last, error, output ready);
endinterface

[design/rse_datapath.sv]
// ---------------------------------------------------------------------------
// rse_datapath
// Coder value, frequency/start table, restoring divider and output register.
// ---------------------------------------------------------------------------
module rse_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rse_pkg::SYMCNT_W-1:0]    cfg_wdata,
	input  logic [rse_pkg::SYM_W-1:0]       in_symbol,
	input  logic [rse_pkg::PROB_BITS-1:0]   in_frequency,
	input  logic [rse_pkg::PROB_BITS-1:0]   in_cum_start,
	input  logic                            in_final,
	input  rse_pkg::rse_cmd_t               cmd,
	output rse_pkg::rse_status_t            status,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [rse_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_last,
	output logic                            out_error
);

	localparam int PB = rse_pkg::PROB_BITS;
	localparam int QB = rse_pkg::QUOT_BITS;
	localparam int VB = rse_pkg::VALUE_BITS;

	logic [2*PB-1:0]               tbl_mem [rse_pkg::TABLE_DEPTH];
	logic [2*PB-1:0]               rd_q;
	logic [rse_pkg::SYMCNT_W-1:0]  symcnt_q;
	logic [rse_pkg::SYM_W-1:0]     sym_q;
	logic                          final_q;
	logic                          failed_q;
	logic [VB-1:0]                 x_q;
	logic [PB-1:0]                 rem_q;
	logic [QB-1:0]                 dq_q;
	logic [rse_pkg::DIV_CW-1:0]    div_cnt_q;
	logic [1:0]                    rn_cnt_q;
	logic [1:0]                    fl_cnt_q;
	logic                          out_valid_q;
	logic [rse_pkg::BYTE_W-1:0]    out_byte_q;
	logic                          out_last_q;
	logic                          out_error_q;

	logic [PB-1:0] f_w;
	logic [PB-1:0] start_w;
	logic          sym_oor;
	logic [PB:0]   trial;
	logic [PB:0]   diff;
	logic          ge;
	logic [VB-1:0] x_new;
	logic          slot_free;
	logic          wr_ok;

	assign f_w     = rd_q[2*PB-1:PB];
	assign start_w = rd_q[PB-1:0];
	assign sym_oor = ({1'b0, sym_q} >= symcnt_q)
		|| ({1'b0, sym_q} >= rse_pkg::SYMCNT_W'(rse_pkg::TABLE_DEPTH));
	assign wr_ok   = {1'b0, in_symbol} < rse_pkg::SYMCNT_W'(rse_pkg::TABLE_DEPTH);

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, dq_q[QB-1]};
	assign diff  = trial - {1'b0, f_w};
	assign ge    = trial >= {1'b0, f_w};

	assign x_new = VB'({dq_q, {PB{1'b0}}}) + VB'(rem_q) + VB'(start_w);

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		status.failed      = failed_q;
		status.bad         = sym_oor || (f_w == '0);
		status.renorm_need = (x_q >= {f_w, {QB{1'b0}}})
			&& (rn_cnt_q < 2'(rse_pkg::RENORM_MAX));
		status.slot_free   = slot_free;
		status.div_last    = div_cnt_q == rse_pkg::DIV_CW'(QB - 1);
		status.flush_last  = fl_cnt_q == 2'(rse_pkg::FLUSH_BYTES - 1);
		status.item_final  = final_q;
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.tbl_write && wr_ok) begin
			tbl_mem[in_symbol[rse_pkg::TBL_AW-1:0]] <= {in_frequency, in_cum_start};
		end
		if (cmd.load_item) begin
			rd_q <= tbl_mem[in_symbol[rse_pkg::TBL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symcnt_q    <= rse_pkg::SYMCNT_RESET;
			failed_q    <= 1'b0;
			x_q         <= rse_pkg::VALUE_RESET;
			div_cnt_q   <= '0;
			rn_cnt_q    <= '0;
			fl_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				symcnt_q <= cfg_wdata;
			end
			if (cmd.failed_set) begin
				failed_q <= 1'b1;
			end else if (cmd.failed_clr) begin
				failed_q <= 1'b0;
			end
			if (cmd.load_item) begin
				rn_cnt_q <= '0;
				fl_cnt_q <= '0;
			end
			if (cmd.value_reset) begin
				x_q <= rse_pkg::VALUE_RESET;
			end else if (cmd.emit_renorm || cmd.emit_flush) begin
				x_q <= x_q >> 8;
			end else if (cmd.update) begin
				x_q <= x_new;
			end
			if (cmd.emit_renorm) begin
				rn_cnt_q <= rn_cnt_q + 2'd1;
			end
			if (cmd.emit_flush) begin
				fl_cnt_q <= fl_cnt_q + 2'd1;
			end
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + rse_pkg::DIV_CW'(1);
			end
			if (cmd.emit_err || cmd.emit_renorm || cmd.emit_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			sym_q   <= in_symbol;
			final_q <= in_final;
		end
		if (cmd.div_init) begin
			rem_q <= x_q[VB-1:QB];
			dq_q  <= x_q[QB-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[PB-1:0] : trial[PB-1:0];
			dq_q  <= {dq_q[QB-2:0], ge};
		end
		if (cmd.emit_err) begin
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_error_q <= 1'b1;
		end else if (cmd.emit_renorm || cmd.emit_flush) begin
			out_byte_q  <= x_q[rse_pkg::BYTE_W-1:0] & rse_pkg::BYTE_MASK;
			out_last_q  <= cmd.emit_flush
				&& (fl_cnt_q == 2'(rse_pkg::FLUSH_BYTES - 1));
			out_error_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_error = out_error_q;

endmodule

[design/rse_ctrl.sv]
// ---------------------------------------------------------------------------
// rse_ctrl
// Sequencer: lookup, error, renormalize, divide, update and flush steps.
// ---------------------------------------------------------------------------
module rse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_action,
	input  logic                 in_final,
	output logic                 in_ready,
	input  rse_pkg::rse_status_t status,
	output rse_pkg::rse_cmd_t    cmd
);

	rse_pkg::rse_state_t state_q;
	rse_pkg::rse_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			rse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_action) begin
						cmd.tbl_write = 1'b1;
					end else begin
						cmd.load_item = 1'b1;
						if (status.failed) begin
							// drop until the final symbol, then restart
							if (in_final) begin
								cmd.value_reset = 1'b1;
								cmd.failed_clr  = 1'b1;
							end
						end else begin
							state_d = rse_pkg::ST_LOOKUP;
						end
					end
				end
			end
			rse_pkg::ST_LOOKUP: begin
				state_d = status.bad ? rse_pkg::ST_ERR : rse_pkg::ST_RENORM;
			end
			rse_pkg::ST_ERR: begin
				if (status.slot_free) begin
					cmd.emit_err = 1'b1;
					if (status.item_final) begin
						cmd.value_reset = 1'b1;
					end else begin
						cmd.failed_set = 1'b1;
					end
					state_d = rse_pkg::ST_IDLE;
				end
			end
			rse_pkg::ST_RENORM: begin
				if (status.renorm_need) begin
					cmd.emit_renorm = status.slot_free;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = rse_pkg::ST_DIV;
				end
			end
			rse_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = rse_pkg::ST_UPDATE;
				end
			end
			rse_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = status.item_final ? rse_pkg::ST_FLUSH : rse_pkg::ST_IDLE;
			end
			rse_pkg::ST_FLUSH: begin
				if (status.slot_free) begin
					cmd.emit_flush = 1'b1;
					if (status.flush_last) begin
						cmd.value_reset = 1'b1;
						state_d         = rse_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rse_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[design/rans_static_encoder.sv]
// ---------------------------------------------------------------------------
// rans_static_encoder
// Byte-wise rANS encoder with a static frequency/start table.
// ---------------------------------------------------------------------------
//  channel   dir  beat
//  sym_in    in   table load (action 0) or symbol to encode (action 1)
//  code_out  out  coded byte, last flush byte flag, or error
//  cfg_we    in   symbol_count write (cfg_wdata)
//
// Encode: accept, table read, then an error beat for a bad symbol, or up
// to RENORM_MAX renormalize bytes, a bit-serial restoring divide over
// QUOT_BITS (15) quotient bits and an update. A final symbol adds
// FLUSH_BYTES (4) flush bytes. Emit cycles hold while the output register
// is full and not taken. Reset is asynchronous; no memory clearing pass.
// ---------------------------------------------------------------------------
`include "rans_static_encoder_assert.svh"

module rans_static_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rse_pkg::SYMCNT_W-1:0] cfg_wdata,
	rse_sym_if.sink                      sym_in,
	rse_code_if.source                   code_out
);

	rse_pkg::rse_cmd_t    cmd;
	rse_pkg::rse_status_t status;
	logic                 in_ready;

	assign sym_in.ready = in_ready;

	rse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sym_in.valid),
		.in_action (sym_in.action),
		.in_final  (sym_in.is_final),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rse_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_symbol    (sym_in.symbol),
		.in_frequency (sym_in.frequency),
		.in_cum_start (sym_in.cum_start),
		.in_final     (sym_in.is_final),
		.cmd          (cmd),
		.status       (status),
		.out_ready    (code_out.ready),
		.out_valid    (code_out.valid),
		.out_byte     (code_out.out_byte),
		.out_last     (code_out.out_last),
		.out_error    (code_out.error)
	);

	// never load the output register over an untaken beat
	`RSE_ASSERT_IMP(a_load_free, cmd.emit_err || cmd.emit_renorm || cmd.emit_flush, status.slot_free)
	`RSE_ASSERT_IMP(a_one_emit, 1'b1, $onehot0({cmd.emit_err, cmd.emit_renorm, cmd.emit_flush}))
	// a live encode beat makes the block busy
	`RSE_ASSERT_NXT(a_busy, sym_in.valid && sym_in.ready && sym_in.action && !status.failed, !sym_in.ready)
	`RSE_ASSERT_IMP(a_err_beat, code_out.valid && code_out.error, !code_out.out_last && code_out.out_byte == 8'd0)

endmodule
